### src/ents_pkg.sv
package ents_pkg;

	// Field widths of the stream and the configuration registers
	localparam int MAG_W = 8;
	localparam int DIR_W = 2;
	localparam int REG_W = 11;

	// Register values after reset
	localparam int WIDTH_RESET = 640;
	localparam int HEIGHT_RESET = 480;
	localparam logic [MAG_W-1:0] LOW_RESET = 8'd51;
	localparam logic [MAG_W-1:0] HIGH_RESET = 8'd127;

	// Value given to a strong edge
	localparam logic [MAG_W-1:0] STRONG_EDGE = 8'd255;

	typedef logic [MAG_W-1:0] mag_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_LOW    = 2'd2,
		CFG_HIGH   = 2'd3
	} cfg_reg_t;

	// Gradient direction codes
	typedef enum logic [DIR_W-1:0] {
		DIR_HORZ    = 2'd0,
		DIR_DIAG45  = 2'd1,
		DIR_VERT    = 2'd2,
		DIR_DIAG135 = 2'd3
	} dir_t;

	// Which sides of the 3x3 window fall outside the image
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} border_t;

	// One pixel request into the row buffers
	typedef struct packed {
		logic valid;
		mag_t mag;
		dir_t dir;
	} row_req_t;

endpackage

### src/ents_row_buf.sv
module ents_row_buf #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [$clog2(MAX_WIDTH)-1:0]   addr,
	input  ents_pkg::row_req_t             req,
	output ents_pkg::mag_t                 top,
	output ents_pkg::mag_t                 mid,
	output ents_pkg::dir_t                 dir_rd
);
	import ents_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	// Row two above, row one above, and direction of row one above, per column.
	// Entries never written are only read for window positions outside the image,
	// which are masked, so the stores need no clearing.
	mag_t up_mem  [MAX_WIDTH];
	mag_t mid_mem [MAX_WIDTH];
	dir_t dir_mem [MAX_WIDTH];

	logic          pend_s1;
	logic [CW-1:0] addr_s1;
	mag_t          up_rd_s1;
	mag_t          mid_rd_s1;
	dir_t          dir_rd_s1;
	logic          fwd_s1;
	mag_t          fwd_data_s1;

	// Request in stage one, which still owes its upper-row write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (adv) begin
			pend_s1 <= req.valid;
		end
	end

	// Middle row and direction: read the old entry, write the new pixel
	always_ff @(posedge clk) begin
		if (adv) begin
			mid_rd_s1 <= mid_mem[addr];
			dir_rd_s1 <= dir_mem[addr];
			if (req.valid) begin
				mid_mem[addr] <= req.mag;
				dir_mem[addr] <= req.dir;
			end
		end
	end

	// Upper row takes the old middle entry from the stage-one read register
	always_ff @(posedge clk) begin
		if (adv) begin
			up_rd_s1 <= up_mem[addr];
			if (pend_s1) begin
				up_mem[addr_s1] <= mid_rd_s1;
			end
		end
	end

	// Bypass for a one-pixel-wide image, where the next read hits the pending write
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1     <= addr;
			fwd_s1      <= pend_s1 && (addr_s1 == addr);
			fwd_data_s1 <= mid_rd_s1;
		end
	end

	assign top    = fwd_s1 ? fwd_data_s1 : up_rd_s1;
	assign mid    = mid_rd_s1;
	assign dir_rd = dir_rd_s1;

endmodule

### src/ents_suppress.sv
module ents_suppress (
	input  ents_pkg::mag_t [8:0]  win,
	input  ents_pkg::border_t     brd,
	input  ents_pkg::dir_t        dir,
	input  ents_pkg::mag_t        low_thr,
	input  ents_pkg::mag_t        high_thr,
	output ents_pkg::mag_t        thin,
	output ents_pkg::mag_t        strength
);
	import ents_pkg::*;

	mag_t [8:0] nb;
	mag_t       n1;
	mag_t       n2;

	// Neighbors outside the image read as zero
	always_comb begin
		nb = win;
		if (brd.top) begin
			nb[0] = '0; nb[1] = '0; nb[2] = '0;
		end
		if (brd.bottom) begin
			nb[6] = '0; nb[7] = '0; nb[8] = '0;
		end
		if (brd.left) begin
			nb[0] = '0; nb[3] = '0; nb[6] = '0;
		end
		if (brd.right) begin
			nb[2] = '0; nb[5] = '0; nb[8] = '0;
		end
	end

	// Pick the two neighbors along the gradient direction
	always_comb begin
		case (dir)
			DIR_HORZ: begin
				n1 = nb[3]; n2 = nb[5];
			end
			DIR_DIAG45: begin
				n1 = nb[0]; n2 = nb[8];
			end
			DIR_VERT: begin
				n1 = nb[1]; n2 = nb[7];
			end
			default: begin
				n1 = nb[2]; n2 = nb[6];
			end
		endcase
	end

	// Keep only a strict local maximum, then classify against the thresholds
	always_comb begin
		thin = (n1 >= nb[4] || n2 >= nb[4]) ? '0 : nb[4];
		if (thin < low_thr) begin
			strength = '0;
		end else if (thin < high_thr) begin
			strength = high_thr;
		end else begin
			strength = STRONG_EDGE;
		end
	end

endmodule

### src/edge_nonmax_suppress_threshold.sv
// Channel  | Direction | Contents
// s_*      | in        | pixel: magnitude, direction, flush flag in tuser
// m_*      | out       | result: thinned magnitude, edge strength, last pixel in tlast
// cfg_*    | in        | register write: index and data
//
// One pixel is accepted every cycle unless the output stalls; for the request that
// completes a window, the row buffers are read at the accepting edge, then the window
// shifts, then the compare is registered at the output. Results trail the input by
// one row plus one pixel, so W + 1 flush requests drain a frame. Reset clears the
// counters and stage valids and loads the default registers. A stalled output holds
// the whole pipeline and input ready drops only while the output register is full
// and not taken.
module edge_nonmax_suppress_threshold #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [7:0] magnitude, [9:8] direction
	input  logic                           s_tuser,   // [0] flush
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,   // [7:0] thinned_magnitude, [15:8] edge_strength
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  ents_pkg::cfg_reg_t             cfg_index,
	input  logic [ents_pkg::REG_W-1:0]     cfg_data
);
	import ents_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
	localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);
	localparam logic [RW-1:0] H_LAST_RST = RW'(H_RST - 1);

	// Configuration
	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;
	mag_t          low_q;
	mag_t          high_q;
	logic [31:0]   cfg_wide;
	logic [CW-1:0] w_last_d;
	logic [RW-1:0] h_last_d;
	logic          cfg_wr;

	// Frame position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Front end
	logic          adv;
	logic          acc;
	logic          take;
	logic          data_phase;
	mag_t          mag_in;
	dir_t          dir_in;
	logic          has;
	logic [RW-1:0] tr;
	logic [CW-1:0] tc;
	border_t       brd;
	logic          last;
	row_req_t      req;

	// Stage one
	logic    v_s1;
	logic    has_s1;
	border_t brd_s1;
	logic    last_s1;
	mag_t    mag_s1;
	mag_t    top_rd;
	mag_t    mid_rd;
	dir_t    dir_rd;

	// Stage two
	logic       v_s2;
	border_t    brd_s2;
	logic       last_s2;
	dir_t       dir_s2;
	dir_t       held_dir_q;
	mag_t [8:0] win_q;

	// Result
	mag_t thin;
	mag_t strength;
	logic out_valid_q;
	mag_t thin_q;
	mag_t strength_q;
	logic last_q;

	// Saturate a size write to 1..MAX and keep it as a last index
	always_comb begin
		cfg_wide = 32'(cfg_data);
		if (cfg_data == '0) begin
			w_last_d = '0;
			h_last_d = '0;
		end else begin
			w_last_d = (cfg_wide > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(cfg_wide - 32'd1);
			h_last_d = (cfg_wide > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) : RW'(cfg_wide - 32'd1);
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= W_LAST_RST;
			h_last_q <= H_LAST_RST;
			low_q    <= LOW_RESET;
			high_q   <= HIGH_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_WIDTH:  w_last_q <= w_last_d;
				CFG_HEIGHT: h_last_q <= h_last_d;
				CFG_LOW:    low_q    <= cfg_data[MAG_W-1:0];
				CFG_HIGH:   high_q   <= cfg_data[MAG_W-1:0];
				default:    low_q    <= low_q;
			endcase
		end
	end

	// Pipeline moves whenever the output register is free or being taken
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && s_tready;

	// Once every pixel of the frame is in, each request is padding
	assign data_phase = (row_q <= h_last_q);
	assign take       = acc && !(data_phase && s_tuser);
	assign mag_in     = data_phase ? s_tdata[MAG_W-1:0] : '0;
	assign dir_in     = data_phase ? dir_t'(s_tdata[MAG_W+DIR_W-1:MAG_W]) : DIR_HORZ;

	// The pixel whose window completes with this request
	always_comb begin
		if (col_q != '0) begin
			has = (row_q != '0);
			tr  = row_q - RW'(1);
			tc  = col_q - CW'(1);
		end else begin
			has = (row_q > RW'(1));
			tr  = row_q - RW'(2);
			tc  = w_last_q;
		end
		brd.top    = (tr == '0);
		brd.bottom = (tr == h_last_q);
		brd.left   = (tc == '0);
		brd.right  = (tc == w_last_q);
		last       = brd.bottom && brd.right;
	end

	// Column and row counters; the last pixel or a size write starts a new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (has && last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign req.valid = take;
	assign req.mag   = mag_in;
	assign req.dir   = dir_in;

	ents_row_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_row_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.addr   (col_q),
		.req    (req),
		.top    (top_rd),
		.mid    (mid_rd),
		.dir_rd (dir_rd)
	);

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			has_s1  <= has;
			brd_s1  <= brd;
			last_s1 <= last;
			mag_s1  <= mag_in;
		end
	end

	// Stage two control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && has_s1;
		end
	end

	// Shift the window by one column and carry the target's direction
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			win_q[0]   <= win_q[1];
			win_q[1]   <= win_q[2];
			win_q[2]   <= top_rd;
			win_q[3]   <= win_q[4];
			win_q[4]   <= win_q[5];
			win_q[5]   <= mid_rd;
			win_q[6]   <= win_q[7];
			win_q[7]   <= win_q[8];
			win_q[8]   <= mag_s1;
			dir_s2     <= held_dir_q;
			held_dir_q <= dir_rd;
			brd_s2     <= brd_s1;
			last_s2    <= last_s1;
		end
	end

	ents_suppress u_suppress (
		.win      (win_q),
		.brd      (brd_s2),
		.dir      (dir_s2),
		.low_thr  (low_q),
		.high_thr (high_q),
		.thin     (thin),
		.strength (strength)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			thin_q     <= thin;
			strength_q <= strength;
			last_q     <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {strength_q, thin_q};
	assign m_tlast  = last_q;

endmodule
